// ----- rtl/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the lru key-value cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

   localparam int LKVC_ENTRIES = 16;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int CAP_W   = 5;
   localparam int CSR_W   = 32;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_CAPACITY = '0;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_COMMIT
   } lkvc_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic lookup;
      logic decide;
      logic commit;
   } lkvc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } lkvc_status_type;

endpackage

`default_nettype wire

// ----- rtl/lru_key_value_cache_core.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// usage:
//   req channel: one get (tuser = 0) or put (tuser = 1) per transaction,
//     tdata = {write_value, lookup_key}.
//   rsp channel: one result per request, tuser = {evicted, found},
//     tdata = {evicted_key, read_value}.
//   apb port: capacity_limit at address 0; any write to it empties the
//     cache. writes are expected only while no request is in flight.
//   the result is registered at the commit step, after the capture, lookup
//     and decide steps of the sequencer; a new request is taken only after
//     the last one is committed. the lookup compares all entry keys at
//     once, so the request rate does not depend on ENTRIES.
//   a finished result waits in the output register while the next
//     request is taken; if rsp_tready stays low the commit step holds and
//     the following request waits in the sequencer.
//   reset: cache empty, capacity_limit = 16, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache_core
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = LKVC_ENTRIES
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [63:0]           req_tdata,   // lookup_key, write_value
   input  wire logic [0:0]            req_tuser,   // command
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [63:0]                rsp_tdata,   // read_value, evicted_key
   output logic [1:0]                 rsp_tuser,   // found, evicted
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_W-1:0]      pwdata,
   output logic [CSR_W-1:0]           prdata,
   output logic                       pready
);

   logic [CAP_W-1:0] capacity_ff;
   logic             csr_hit;
   logic             csr_write;

   lkvc_cmd_type     cmd;
   lkvc_status_type  status;

   logic               rsp_found;
   logic [VALUE_W-1:0] rsp_read_value;
   logic               rsp_evicted;
   logic [KEY_W-1:0]   rsp_evicted_key;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_CAPACITY);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_write) begin
         capacity_ff <= pwdata[CAP_W-1:0];
      end
   end

   assign prdata = csr_hit ? CSR_W'(capacity_ff) : '0;

   lkvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lkvc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .clear           (csr_write),
      .capacity        (capacity_ff),
      .cmd             (cmd),
      .status          (status),
      .req_command     (req_tuser[0]),
      .req_key         (req_tdata[KEY_W-1:0]),
      .req_value       (req_tdata[KEY_W+VALUE_W-1:KEY_W]),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_found       (rsp_found),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key)
   );

   assign rsp_tdata = {rsp_evicted_key, rsp_read_value};
   assign rsp_tuser = {rsp_evicted, rsp_found};

endmodule

`default_nettype wire

// ----- rtl/lkvc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer for one transaction: capture, lookup, decide, commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkvc_ctrl
   import lkvc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire lkvc_status_type status,
   output lkvc_cmd_type         cmd
);

   lkvc_state_type state_ff;
   lkvc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.lookup  = 1'b0;
      cmd.decide  = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/lkvc_datapath.sv -----
// ----------------------------------------------------------------------------
// lkvc_datapath
// Entry lanes (key, rank, valid), value memory and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkvc_datapath
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = LKVC_ENTRIES
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                clear,
   input  wire logic [CAP_W-1:0]    capacity,
   input  wire lkvc_cmd_type        cmd,
   output lkvc_status_type          status,
   input  wire logic                req_command,
   input  wire logic [KEY_W-1:0]    req_key,
   input  wire logic [VALUE_W-1:0]  req_value,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic                     rsp_found,
   output logic [VALUE_W-1:0]       rsp_read_value,
   output logic                     rsp_evicted,
   output logic [KEY_W-1:0]         rsp_evicted_key
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int EW     = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   // entry lanes
   logic [KEY_W-1:0]  key_ff  [ENTRIES];
   logic [KEY_W-1:0]  key_in  [ENTRIES];
   logic [RANK_W-1:0] rank_ff [ENTRIES];
   logic [RANK_W-1:0] rank_in [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [OCC_W-1:0]   occ_ff;
   logic [OCC_W-1:0]   occ_in;

   logic [VALUE_W-1:0] value_mem [ENTRIES];
   logic [VALUE_W-1:0] rd_data_ff;

   // captured transaction
   logic               put_req_ff;
   logic [KEY_W-1:0]   key_req_ff;
   logic [VALUE_W-1:0] value_req_ff;

   // lookup stage
   logic [ENTRIES-1:0] match_ff;
   logic [ENTRIES-1:0] victim_ff;
   logic [ENTRIES-1:0] match_in;
   logic [ENTRIES-1:0] victim_in;
   logic [RANK_W-1:0]  oldest_rank;

   // decide stage
   logic               hit_any;
   logic [IDX_W-1:0]   hit_idx;
   logic [IDX_W-1:0]   free_idx;
   logic [ENTRIES-1:0] free_vec;
   logic               full;
   logic               evict_now;
   logic [EW-1:0]      cap_eff;
   logic [KEY_W-1:0]   victim_key;
   logic [RANK_W-1:0]  hit_rank;

   logic               hit_ff;
   logic               evict_ff;
   logic [IDX_W-1:0]   slot_ff;
   logic [RANK_W-1:0]  hit_rank_ff;
   logic [KEY_W-1:0]   ev_key_ff;

   // result register
   logic               rsp_valid_ff;
   logic               found_ff;
   logic [VALUE_W-1:0] read_value_ff;
   logic               evicted_ff;
   logic [KEY_W-1:0]   evicted_key_ff;

   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         put_req_ff   <= (req_command == CMD_PUT);
         key_req_ff   <= req_key;
         value_req_ff <= req_value;
      end
   end

   // lookup: parallel compare per lane
   assign oldest_rank = RANK_W'(occ_ff - 1'b1);

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i]  = valid_ff[i] && (key_ff[i] == key_req_ff);
         victim_in[i] = valid_ff[i] && (rank_ff[i] == oldest_rank);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         match_ff  <= match_in;
         victim_ff <= victim_in;
      end
   end

   // decide: encode slots, pick the victim
   always_comb begin
      if (capacity == '0) begin
         cap_eff = EW'(1);
      end else if (EW'(capacity) > EW'(ENTRIES)) begin
         cap_eff = EW'(ENTRIES);
      end else begin
         cap_eff = EW'(capacity);
      end
   end

   assign full      = EW'(occ_ff) >= cap_eff;
   assign hit_any   = |match_ff;
   assign evict_now = put_req_ff && !hit_any && full;
   assign free_vec  = ~valid_ff | (evict_now ? victim_ff : '0);

   always_comb begin
      hit_idx    = '0;
      free_idx   = '0;
      victim_key = '0;
      hit_rank   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (free_vec[i]) begin
            free_idx = IDX_W'(i);
         end
      end
      for (int i = 0; i < ENTRIES; i++) begin
         victim_key = victim_key | (key_ff[i] & {KEY_W{victim_ff[i]}});
         hit_rank   = hit_rank | (rank_ff[i] & {RANK_W{match_ff[i]}});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         hit_ff      <= hit_any;
         evict_ff    <= evict_now;
         slot_ff     <= hit_any ? hit_idx : free_idx;
         hit_rank_ff <= hit_rank;
         ev_key_ff   <= evict_now ? victim_key : '0;
      end
   end

   // value memory
   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         rd_data_ff <= value_mem[hit_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && put_req_ff) begin
         value_mem[slot_ff] <= value_req_ff;
      end
   end

   // commit: age ranks, insert or promote; a clear empties all lanes
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         key_in[i]  = key_ff[i];
      end
      if (clear) begin
         valid_in = '0;
         occ_in   = '0;
      end else if (cmd.commit) begin
         if (hit_ff) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && (rank_ff[i] < hit_rank_ff)) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
               if (slot_ff == IDX_W'(i)) begin
                  rank_in[i] = '0;
               end
            end
         end else if (put_req_ff) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && !(evict_ff && victim_ff[i])) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
               if (evict_ff && victim_ff[i]) begin
                  valid_in[i] = 1'b0;
               end
               if (slot_ff == IDX_W'(i)) begin
                  key_in[i]   = key_req_ff;
                  rank_in[i]  = '0;
                  valid_in[i] = 1'b1;
               end
            end
            occ_in = evict_ff ? occ_ff : occ_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         key_ff[i]  <= key_in[i];
         rank_ff[i] <= rank_in[i];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         found_ff       <= hit_ff;
         read_value_ff  <= (hit_ff && !put_req_ff) ? rd_data_ff : '0;
         evicted_ff     <= evict_ff;
         evicted_key_ff <= ev_key_ff;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_read_value  = read_value_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_key = evicted_key_ff;

endmodule

`default_nettype wire

// ----- rtl/lkvc_checker.sv -----
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks of the lru key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkvc_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [63:0]           rsp_tdata,   // read_value, evicted_key
   input wire logic [1:0]            rsp_tuser    // found, evicted
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   // one request at a time in the sequencer
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in flight");

   // a hit never evicts
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("result reports both hit and eviction");

   // read value only on a hit
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[31:0] == 32'd0)
      else $error("read value nonzero on a miss");

   // evicted key only with an eviction
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[63:32] == 32'd0)
      else $error("evicted key nonzero without eviction");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (.*);

`default_nettype wire

// ----- tb/lkvc_checker.sv -----
// ----------------------------------------------------------------------------
// lkvc_tb_checker
// Watches the request, result and register ports of the lru key-value cache,
// keeps its own copy of the cache contents and recency order, and compares
// each result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvc_tb_checker
   import lkvc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [63:0]           req_tdata,   // lookup_key, write_value
   input  wire logic [0:0]            req_tuser,   // command
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [63:0]           rsp_tdata,   // read_value, evicted_key
   input  wire logic [1:0]            rsp_tuser,   // found, evicted
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_W-1:0]      pwdata,
   input  wire logic [CSR_W-1:0]      prdata,
   input  wire logic                  pready,
   output int                         mismatch_count,
   output int                         outstanding,
   output int                         hit_count,
   output int                         evict_count
);

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] read_value;
      logic               evicted;
      logic [KEY_W-1:0]   evicted_key;
   } cache_result_type;

   cache_result_type   expected_results[$];
   logic [KEY_W-1:0]   entry_key   [LKVC_ENTRIES];
   logic [VALUE_W-1:0] entry_value [LKVC_ENTRIES];
   logic               entry_live  [LKVC_ENTRIES];
   int                 entry_age   [LKVC_ENTRIES];   // 0 = most recent
   int                 live_count;
   logic [CAP_W-1:0]   capacity_reg;
   int                 errors;
   int                 hits;
   int                 evictions;

   initial begin
      errors    = 0;
      hits      = 0;
      evictions = 0;
   end

   function automatic void empty_cache();
      int i;
      for (i = 0; i < LKVC_ENTRIES; i++) begin
         entry_live[i] = 1'b0;
      end
      live_count = 0;
   endfunction

   function automatic cache_result_type predict_access(input logic cmd,
                                                       input logic [KEY_W-1:0] key,
                                                       input logic [VALUE_W-1:0] value);
      cache_result_type r;
      int               i;
      int               hit_slot;
      int               slot;
      int               limit;
      r        = '0;
      hit_slot = -1;
      slot     = -1;
      for (i = 0; i < LKVC_ENTRIES; i++) begin
         if (hit_slot < 0 && entry_live[i] && entry_key[i] == key) begin
            hit_slot = i;
         end
      end
      if (hit_slot >= 0) begin
         r.found = 1'b1;
         for (i = 0; i < LKVC_ENTRIES; i++) begin
            if (entry_live[i] && entry_age[i] < entry_age[hit_slot]) begin
               entry_age[i]++;
            end
         end
         entry_age[hit_slot] = 0;
         if (cmd == CMD_GET) begin
            r.read_value = entry_value[hit_slot];
         end else begin
            entry_value[hit_slot] = value;
         end
      end else if (cmd == CMD_PUT) begin
         // zero acts as one, anything above the entry count as full size
         limit = int'(capacity_reg);
         if (limit < 1) begin
            limit = 1;
         end
         if (limit > LKVC_ENTRIES) begin
            limit = LKVC_ENTRIES;
         end
         if (live_count >= limit) begin
            // oldest entry goes, lowest index on a tie
            for (i = 0; i < LKVC_ENTRIES; i++) begin
               if (entry_live[i] && (slot < 0 || entry_age[i] > entry_age[slot])) begin
                  slot = i;
               end
            end
            if (slot >= 0) begin
               r.evicted         = 1'b1;
               r.evicted_key     = entry_key[slot];
               entry_live[slot]  = 1'b0;
               live_count--;
            end
         end
         slot = -1;
         for (i = 0; i < LKVC_ENTRIES; i++) begin
            if (slot < 0 && !entry_live[i]) begin
               slot = i;
            end
         end
         for (i = 0; i < LKVC_ENTRIES; i++) begin
            if (entry_live[i]) begin
               entry_age[i]++;
            end
         end
         entry_key[slot]   = key;
         entry_value[slot] = value;
         entry_age[slot]   = 0;
         entry_live[slot]  = 1'b1;
         live_count++;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cache_result_type got;
      cache_result_type want;
      if (reset) begin
         expected_results.delete();
         empty_cache();
         capacity_reg = CAPACITY_RESET;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.found       = rsp_tuser[0];
            got.evicted     = rsp_tuser[1];
            got.read_value  = rsp_tdata[31:0];
            got.evicted_key = rsp_tdata[63:32];
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t tb: result transaction with nothing expected: %p", $time, got);
               end
            end else begin
               want = expected_results.pop_front();
               if (got.found !== want.found || got.read_value !== want.read_value ||
                   got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t tb: result mismatch", $time);
                     $display("   expected found=%0b read_value=%h evicted=%0b evicted_key=%h",
                              want.found, want.read_value, want.evicted, want.evicted_key);
                     $display("   actual   found=%0b read_value=%h evicted=%0b evicted_key=%h",
                              got.found, got.read_value, got.evicted, got.evicted_key);
                  end
               end
               if (want.found) begin
                  hits++;
               end
               if (want.evicted) begin
                  evictions++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(predict_access(req_tuser[0], req_tdata[31:0],
                                                      req_tdata[63:32]));
         end
         if (psel && penable && pready) begin
            if (pwrite) begin
               if ((paddr >> 2) == CSR_IDX_CAPACITY) begin
                  capacity_reg = pwdata[CAP_W-1:0];
                  empty_cache();
               end
            end else if ((paddr >> 2) == CSR_IDX_CAPACITY &&
                         prdata !== CSR_W'(capacity_reg)) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t tb: capacity read back %h, expected %h", $time, prdata,
                           CSR_W'(capacity_reg));
               end
            end
         end
      end
      mismatch_count <= errors;
      outstanding    <= expected_results.size();
      hit_count      <= hits;
      evict_count    <= evictions;
   end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the lru key-value cache: a directed opening over
// field extremes, hits, misses, updates and evictions at small capacities,
// then random phases of gets and puts over per-phase key pools at a range of
// capacity settings, with random idling on both channels and one long
// result-side hold-off that backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import lkvc_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 90;
   localparam int PHASE_ITEMS = 185;
   localparam int NUM_PHASES  = 9;
   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR = {CSR_IDX_CAPACITY, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR = CAPACITY_ADDR + CSR_ADDR_W'(4);

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [63:0]           req_tdata  = '0;   // lookup_key, write_value
   logic [0:0]            req_tuser  = '0;   // command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [63:0]           rsp_tdata;         // read_value, evicted_key
   logic [1:0]            rsp_tuser;         // found, evicted
   logic                  psel       = 1'b0;
   logic                  penable    = 1'b0;
   logic                  pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr      = '0;
   logic [CSR_W-1:0]      pwdata     = '0;
   logic [CSR_W-1:0]      prdata;
   logic                  pready;

   int   mismatch_count;
   int   outstanding;
   int   hit_count;
   int   evict_count;
   int   cycle_count  = 0;
   int   sent_count   = 0;
   int   rsp_stall    = 0;
   logic req_idle_on  = 1'b1;
   logic rsp_idle_on  = 1'b1;
   logic rsp_hold     = 1'b0;

   lru_key_value_cache_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   lkvc_tb_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .hit_count      (hit_count),
      .evict_count    (evict_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // limit stops a hung run, with ample margin over the slowest correct run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // result side: random stall bursts, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset || rsp_hold) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= rsp_stall - 1;
      end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= $urandom_range(0, 6);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_request(input logic cmd, input logic [KEY_W-1:0] key,
                               input logic [VALUE_W-1:0] value);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {value, key};
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   // lower valid and wait until every expected result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_capacity(input logic [CSR_W-1:0] data);
      csr_access(1'b1, CAPACITY_ADDR, data);
      csr_access(1'b0, CAPACITY_ADDR, '0);
   endtask

   // mostly keys from a pool a little larger than the capacity, so hits,
   // updates and evictions all come up; the rest are fresh random keys
   task automatic run_random_phase(input int count, input int cap);
      logic [KEY_W-1:0] pool[$];
      int               pool_size;
      logic             cmd;
      logic [KEY_W-1:0] key;
      pool_size = cap + $urandom_range(1, 6);
      repeat (pool_size) pool.push_back($urandom);
      pool[0] = $urandom_range(0, 1) ? '1 : '0;
      repeat (count) begin
         cmd = $urandom_range(0, 1) ? CMD_PUT : CMD_GET;
         if ($urandom_range(0, 9) < 8) begin
            key = pool[$urandom_range(0, pool_size - 1)];
         end else begin
            key = $urandom;
         end
         send_request(cmd, key, $urandom);
      end
   endtask

   initial begin
      logic [CSR_W-1:0] settings[NUM_PHASES];
      int               cap;
      int               p;
      settings = '{32'h0000_001F, 32'h0000_0001, 32'h0000_0010, 32'h0000_0010,
                   32'h0000_0005, 32'hFFFF_FFE8, 32'h0000_0003, 32'h0000_000C,
                   32'h0000_0010};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, CAPACITY_ADDR, '0);

      // field extremes, hit, miss and update at the reset capacity
      send_request(CMD_PUT, 32'h0000_0000, 32'h8000_0000);
      send_request(CMD_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_request(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(CMD_GET, 32'h0000_0001, 32'h1234_5678);
      send_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
      send_request(CMD_GET, 32'h0000_0000, 32'h5555_5555);
      send_request(CMD_PUT, 32'hA5A5_A5A5, 32'hFFFF_FFFF);
      send_request(CMD_GET, 32'hA5A5_A5A5, 32'hAAAA_AAAA);
      drain();

      // capacity two: store emptied, recency decides the victim
      set_capacity(32'h0000_0002);
      send_request(CMD_GET, 32'h0000_0000, 32'h0);
      send_request(CMD_PUT, 32'h0000_0001, 32'd10);
      send_request(CMD_PUT, 32'h0000_0002, 32'd20);
      send_request(CMD_GET, 32'h0000_0001, 32'h0);
      send_request(CMD_PUT, 32'h0000_0003, 32'd30);
      send_request(CMD_GET, 32'h0000_0002, 32'h0);
      send_request(CMD_PUT, 32'h0000_0001, 32'd11);
      send_request(CMD_PUT, 32'h0000_0004, 32'd40);
      send_request(CMD_GET, 32'h0000_0004, 32'h0);
      drain();

      // capacity zero behaves as one
      set_capacity(32'h0000_0020);
      send_request(CMD_PUT, 32'h0000_0007, 32'd70);
      send_request(CMD_PUT, 32'h0000_0008, 32'd80);
      send_request(CMD_GET, 32'h0000_0008, 32'h0);
      send_request(CMD_GET, 32'h0000_0007, 32'h0);
      drain();

      for (p = 0; p < NUM_PHASES; p++) begin
         set_capacity(settings[p]);
         cap = int'(settings[p][CAP_W-1:0]);
         if (cap < 1) cap = 1;
         if (cap > LKVC_ENTRIES) cap = LKVC_ENTRIES;
         if (p == NUM_PHASES - 1) begin
            req_idle_on <= 1'b0;
            rsp_idle_on <= 1'b0;
         end
         if (p == 3) begin
            // result side holds off while requests keep coming
            fork
               begin
                  rsp_hold <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  rsp_hold <= 1'b0;
               end
               run_random_phase(PHASE_ITEMS, cap);
            join
         end else if (p == 5) begin
            // a write to an unmapped address must leave the contents alone
            run_random_phase(PHASE_ITEMS / 2, cap);
            drain();
            csr_access(1'b1, UNMAPPED_ADDR, 32'h0000_0001);
            csr_access(1'b0, CAPACITY_ADDR, '0);
            run_random_phase(PHASE_ITEMS - PHASE_ITEMS / 2, cap);
         end else begin
            run_random_phase(PHASE_ITEMS, cap);
         end
         drain();
      end

      repeat (10) @(posedge clock);
      $display("tb: %0d gets and puts sent over %0d capacity settings", sent_count,
               NUM_PHASES + 2);
      $display("tb: %0d hits and %0d evictions checked", hit_count, evict_count);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/lkvc_pkg.sv
rtl/lkvc_ctrl.sv
rtl/lkvc_datapath.sv
rtl/lru_key_value_cache_core.sv
rtl/lkvc_checker.sv
tb/lkvc_checker.sv
tb/tb.sv
